/* hdl/serial_dual_motor_command_watchdog_macros.svh */
// Assertion macros for the serial dual motor command watchdog.
// Included by the top level; no other dependencies.
`ifndef SERIAL_DUAL_MOTOR_COMMAND_WATCHDOG_MACROS_SVH
`define SERIAL_DUAL_MOTOR_COMMAND_WATCHDOG_MACROS_SVH
`ifndef ASSERT_OFF
`define SDMCW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdmcw assertion failed");
`define SDMCW_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sdmcw assertion failed");
`else
`define SDMCW_ASSERT(label, clk, rst_n, prop)
`define SDMCW_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* hdl/sdmcw_pkg.sv */
// Types, constants and helper functions for the serial dual motor command watchdog.
// No dependencies.
`default_nettype none

package sdmcw_pkg;

  localparam logic [7:0]  CharNewline  = 8'h0A;
  localparam logic [7:0]  CharMinus    = 8'h2D;
  localparam logic [7:0]  CharComma    = 8'h2C;
  localparam logic [7:0]  CharZero     = 8'h30;
  localparam logic [7:0]  CharNine     = 8'h39;
  localparam logic [7:0]  CharFirstPr  = 8'd32;
  localparam logic [7:0]  CharLastPr   = 8'd126;
  localparam logic [11:0] NumberMax    = 12'd255;
  localparam logic [15:0] ElapsedMax   = 16'hFFFF;

  localparam logic [15:0] TimeoutReset = 16'd400;
  localparam logic [7:0]  MaxLenReset  = 8'd15;

  // configuration register indexes
  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgMaxLen  = 1'b1;

  typedef enum logic [1:0] {
    EvNone     = 2'd0,
    EvCmd      = 2'd1,
    EvReject   = 2'd2,
    EvWatchdog = 2'd3
  } event_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } cmd_in_t;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] left_duty;
    logic       left_reverse;
    logic       left_forward;
    logic [7:0] right_duty;
    logic       right_reverse;
    logic       right_forward;
    logic       drive_active;
  } cmd_out_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       reverse;
    logic       forward;
  } bridge_t;

  typedef struct packed {
    bridge_t right;
    bridge_t left;
  } drive_t;

  // end-of-line report from the parser
  typedef struct packed {
    logic       eol;
    logic       valid;
    logic [8:0] first_speed;
    logic [8:0] second_speed;
  } line_t;

  typedef struct packed {
    event_e ev;
    drive_t drive;
    logic   active;
  } wd_res_t;

  // 9-bit two's complement speed from sign and magnitude
  function automatic logic [8:0] speed9(input logic neg, input logic [7:0] mag);
    logic [8:0] ext;
    ext = {1'b0, mag};
    speed9 = neg ? (9'd0 - ext) : ext;
  endfunction

  function automatic bridge_t bridge_bits(input logic [8:0] s);
    bridge_t    b;
    logic [8:0] mag;
    mag = 9'd0 - s;
    if (s[8]) begin
      b.duty    = mag[7:0];
      b.reverse = 1'b1;
      b.forward = 1'b0;
    end else begin
      b.duty    = s[7:0];
      b.reverse = 1'b0;
      b.forward = (s != 9'd0);
    end
    bridge_bits = b;
  endfunction

endpackage

`default_nettype wire

/* hdl/sdmcw_parser.sv */
// Serial line parser: tracks "[-]digits,[-]digits" one byte per transaction.
// Depends on sdmcw_pkg.
`default_nettype none

module sdmcw_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire sdmcw_pkg::cmd_in_t item_i,
  input  wire logic [7:0]        max_len_i,
  output sdmcw_pkg::line_t       line_o
);

  localparam logic [2:0] PhFirstStart  = 3'd0;
  localparam logic [2:0] PhFirstDigit  = 3'd1;
  localparam logic [2:0] PhFirstMore   = 3'd2;
  localparam logic [2:0] PhSecondStart = 3'd3;
  localparam logic [2:0] PhSecondDigit = 3'd4;
  localparam logic [2:0] PhSecondMore  = 3'd5;

  logic [7:0] len_q, len_d;
  logic       disc_q, disc_d;
  logic [2:0] phase_q, phase_d;
  logic       neg_q, neg_d;
  logic [7:0] num_q, num_d;
  logic [8:0] first_q, first_d;
  logic       err_q, err_d;

  logic [7:0]  c;
  logic        is_byte;
  logic        is_eol;
  logic        printable;
  logic        digit;
  logic        disc_new;
  logic        go_digit;
  logic [7:0]  base;
  logic [11:0] acc;

  assign c         = item_i.rx_byte;
  assign is_byte   = !item_i.operation;
  assign is_eol    = is_byte && (c == sdmcw_pkg::CharNewline);
  assign printable = (c >= sdmcw_pkg::CharFirstPr) && (c <= sdmcw_pkg::CharLastPr);
  assign digit     = (c >= sdmcw_pkg::CharZero) && (c <= sdmcw_pkg::CharNine);
  assign disc_new  = disc_q || !printable || (len_q >= max_len_i);

  always_comb begin
    len_d    = len_q;
    disc_d   = disc_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    num_d    = num_q;
    first_d  = first_q;
    err_d    = err_q;
    go_digit = 1'b0;
    base     = num_q;
    acc      = ({4'd0, base} << 3) + ({4'd0, base} << 1) + {8'd0, c[3:0]};

    if (is_eol) begin
      len_d   = '0;
      disc_d  = 1'b0;
      phase_d = PhFirstStart;
      neg_d   = 1'b0;
      num_d   = '0;
      err_d   = 1'b0;
    end else if (is_byte) begin
      disc_d = disc_new;
      if (!disc_new) begin
        len_d = len_q + 8'd1;
        if (!err_q) begin
          unique case (phase_q)
            PhFirstStart, PhSecondStart: begin
              num_d = '0;
              neg_d = 1'b0;
              base  = '0;
              if (c == sdmcw_pkg::CharMinus) begin
                neg_d   = 1'b1;
                phase_d = phase_q + 3'd1;
              end else begin
                go_digit = 1'b1;
              end
            end
            PhFirstDigit, PhSecondDigit, PhSecondMore: begin
              go_digit = 1'b1;
            end
            PhFirstMore: begin
              if (c == sdmcw_pkg::CharComma) begin
                first_d = sdmcw_pkg::speed9(neg_q, num_q);
                phase_d = PhSecondStart;
              end else begin
                go_digit = 1'b1;
              end
            end
            default: begin
              err_d = 1'b1;
            end
          endcase

          acc = ({4'd0, base} << 3) + ({4'd0, base} << 1) + {8'd0, c[3:0]};
          if (go_digit) begin
            if (!digit) begin
              err_d = 1'b1;
            end else begin
              num_d = acc[7:0];
              if (acc > sdmcw_pkg::NumberMax) begin
                err_d = 1'b1;
              end else if (phase_q == PhFirstStart || phase_q == PhFirstDigit) begin
                phase_d = PhFirstMore;
              end else if (phase_q == PhSecondStart || phase_q == PhSecondDigit) begin
                phase_d = PhSecondMore;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      disc_q  <= 1'b0;
      phase_q <= PhFirstStart;
      neg_q   <= 1'b0;
      num_q   <= '0;
      first_q <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      len_q   <= len_d;
      disc_q  <= disc_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      num_q   <= num_d;
      first_q <= first_d;
      err_q   <= err_d;
    end
  end

  assign line_o.eol          = is_eol;
  assign line_o.valid        = !disc_q && !err_q && (phase_q == PhSecondMore);
  assign line_o.first_speed  = first_q;
  assign line_o.second_speed = sdmcw_pkg::speed9(neg_q, num_q);

endmodule

`default_nettype wire

/* hdl/sdmcw_watchdog.sv */
// Drive hold and command watchdog: applies parsed lines and counts ticks.
// Depends on sdmcw_pkg.
`default_nettype none

module sdmcw_watchdog (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              tick_i,
  input  wire sdmcw_pkg::line_t  line_i,
  input  wire logic [15:0]       timeout_i,
  output sdmcw_pkg::wd_res_t     res_o
);

  logic [15:0]       elapsed_q, elapsed_d;
  logic              active_q, active_d;
  sdmcw_pkg::drive_t drive_q, drive_d;
  sdmcw_pkg::event_e ev;
  logic [15:0]       elapsed_inc;

  // saturating count
  assign elapsed_inc = (elapsed_q != sdmcw_pkg::ElapsedMax) ? (elapsed_q + 16'd1) : elapsed_q;

  always_comb begin
    elapsed_d = elapsed_q;
    active_d  = active_q;
    drive_d   = drive_q;
    ev        = sdmcw_pkg::EvNone;
    if (tick_i) begin
      elapsed_d = elapsed_inc;
      if (active_q && (elapsed_inc >= timeout_i)) begin
        drive_d  = '0;
        active_d = 1'b0;
        ev       = sdmcw_pkg::EvWatchdog;
      end
    end else if (line_i.eol) begin
      if (line_i.valid) begin
        drive_d.left  = sdmcw_pkg::bridge_bits(line_i.first_speed);
        drive_d.right = sdmcw_pkg::bridge_bits(line_i.second_speed);
        elapsed_d     = '0;
        active_d      = 1'b1;
        ev            = sdmcw_pkg::EvCmd;
      end else begin
        // bad line stops the motors but leaves the watchdog running
        drive_d = '0;
        ev      = sdmcw_pkg::EvReject;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      active_q  <= 1'b0;
      drive_q   <= '0;
    end else if (step_i) begin
      elapsed_q <= elapsed_d;
      active_q  <= active_d;
      drive_q   <= drive_d;
    end
  end

  assign res_o.ev     = ev;
  assign res_o.drive  = drive_d;
  assign res_o.active = active_d;

endmodule

`default_nettype wire

/* hdl/serial_dual_motor_command_watchdog.sv */
// Top level of the serial dual motor command watchdog: handshake, config, result register.
// Depends on sdmcw_pkg, sdmcw_parser, sdmcw_watchdog and the macros header.
`default_nettype none
`include "serial_dual_motor_command_watchdog_macros.svh"

// Each input transaction is either one received serial byte or one millisecond
// tick, and yields exactly one result transaction carrying the event code and
// the held drive of both bridges. The block takes one transaction per clock:
// an accepted item sits in an input register, passes through the line parser
// and watchdog logic and lands in the result register, so throughput is one
// item per cycle while the output is not stalled. A stalled result keeps the
// item held in the input register, and a full input register stalls the input.
// Configuration writes (index 0 timeout in ticks, index 1 maximum line length)
// take effect at once and are meant to be done while the block is idle.
module serial_dual_motor_command_watchdog (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sdmcw_pkg::cmd_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sdmcw_pkg::cmd_out_t     out_data_o
);

  logic [15:0]         timeout_q;
  logic [7:0]          max_len_q;
  logic                in_valid_q, in_valid_d;
  sdmcw_pkg::cmd_in_t  in_q;
  logic                out_valid_q, out_valid_d;
  sdmcw_pkg::cmd_out_t out_q, out_d;
  logic                advance;
  logic                in_take;
  sdmcw_pkg::line_t    line;
  sdmcw_pkg::wd_res_t  wd_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= sdmcw_pkg::TimeoutReset;
      max_len_q <= sdmcw_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdmcw_pkg::CfgTimeout: timeout_q <= cfg_wdata_i;
        sdmcw_pkg::CfgMaxLen:  max_len_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  sdmcw_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_q),
    .max_len_i (max_len_q),
    .line_o    (line)
  );

  sdmcw_watchdog u_watchdog (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .tick_i    (in_q.operation),
    .line_i    (line),
    .timeout_i (timeout_q),
    .res_o     (wd_res)
  );

  always_comb begin
    out_d.event_res     = wd_res.ev;
    out_d.left_duty     = wd_res.drive.left.duty;
    out_d.left_reverse  = wd_res.drive.left.reverse;
    out_d.left_forward  = wd_res.drive.left.forward;
    out_d.right_duty    = wd_res.drive.right.duty;
    out_d.right_reverse = wd_res.drive.right.reverse;
    out_d.right_forward = wd_res.drive.right.forward;
    out_d.drive_active  = wd_res.active;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SDMCW_ASSERT(a_cmd_sets_active, clk_i, rst_ni, (out_valid_q && out_q.event_res == sdmcw_pkg::EvCmd) |-> out_q.drive_active)
  `SDMCW_ASSERT(a_wd_stops_all, clk_i, rst_ni, (out_valid_q && out_q.event_res == sdmcw_pkg::EvWatchdog) |-> (!out_q.drive_active && out_q.left_duty == 8'd0 && out_q.right_duty == 8'd0))
  `SDMCW_ASSERT(a_bridge_excl, clk_i, rst_ni, out_valid_q |-> (!(out_q.left_forward && out_q.left_reverse) && !(out_q.right_forward && out_q.right_reverse)))
  `SDMCW_ASSERT_NEXT(a_held_item_kept, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)

endmodule

`default_nettype wire
